@@ rtl/core/tscd_pkg.sv @@
// ----------------------------------------------------------------------------
// tscd_pkg
// Shared types and constants of the Taylor sine/cosine block: datapath
// command and status words, fixed-point widths and reciprocal constants.
// ----------------------------------------------------------------------------
`default_nettype none

package tscd_pkg;

    // Field widths.
    localparam int DEG_W     = 18;   // angle in degrees, signed Q9.8
    localparam int RAD_W     = 20;   // angle in radians, signed Q3.16
    localparam int SUM_W     = 24;   // sine and cosine, signed Q7.16
    localparam int CNT_W     = 4;    // term count register
    localparam int S_DATA_W  = 24;   // input tdata, whole bytes
    localparam int M_DATA_W  = 72;   // output tdata, whole bytes

    // Internal widths. A term never exceeds 8^8/8! in Q16, below 2^25, and
    // the partial sums stay below e^8 in Q16, below 2^28.
    localparam int TERM_W    = 25;
    localparam int ACC_W     = 29;
    localparam int X_W       = 30;   // scaled degree magnitude plus rounding
    localparam int A_W       = 28;   // rounded term product before divide by k
    localparam int MUL_A_W   = 30;
    localparam int MUL_B_W   = 29;
    localparam int PROD_W    = MUL_A_W + MUL_B_W;
    localparam int K_W       = 5;    // series index, up to nineteen

    // Degree to radian conversion: rad = round(deg * 5024 / 1125).
    localparam logic [10:0] DEG_HALF   = 11'd562;
    localparam logic [10:0] DEG_DEN    = 11'd1125;
    localparam logic [19:0] DEG_RECIP  = 20'd954437;   // floor(2^30 / 1125)
    localparam int          DEG_SHIFT  = 30;
    localparam int          K_SHIFT    = 28;           // shift of the 1/k table

    localparam logic [TERM_W-1:0] ONE_Q16     = 25'd65536;
    localparam logic [RAD_W-1:0]  RAD_POS_LIM = 20'd524287;
    localparam logic [RAD_W-1:0]  RAD_NEG_LIM = 20'd524288;

    // Datapath operations issued by the controller.
    typedef enum logic [2:0] {
        OP_IDLE,
        OP_LOAD,
        OP_CONV_RECIP,
        OP_CONV_FIX,
        OP_TERM_MUL,
        OP_TERM_RECIP,
        OP_TERM_FIX,
        OP_PUBLISH
    } dp_op_t;

    typedef struct packed {
        dp_op_t         op;
        logic [K_W-1:0] k;          // index of the term being built
        logic           series_on;  // at least one term is summed
    } dp_cmd_t;

    typedef struct packed {
        logic out_free;             // output register can take a new word
    } dp_status_t;

    // floor(2^28 / k) for the series indexes one through nineteen.
    function automatic logic [MUL_B_W-1:0] recip_k(input logic [K_W-1:0] k);
        logic [MUL_B_W-1:0] r;
        case (k)
            5'd1:    r = 29'd268435456;
            5'd2:    r = 29'd134217728;
            5'd3:    r = 29'd89478485;
            5'd4:    r = 29'd67108864;
            5'd5:    r = 29'd53687091;
            5'd6:    r = 29'd44739242;
            5'd7:    r = 29'd38347922;
            5'd8:    r = 29'd33554432;
            5'd9:    r = 29'd29826161;
            5'd10:   r = 29'd26843545;
            5'd11:   r = 29'd24403223;
            5'd12:   r = 29'd22369621;
            5'd13:   r = 29'd20648881;
            5'd14:   r = 29'd19173961;
            5'd15:   r = 29'd17895697;
            5'd16:   r = 29'd16777216;
            5'd17:   r = 29'd15790320;
            5'd18:   r = 29'd14913080;
            5'd19:   r = 29'd14128181;
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

@@ rtl/core/tscd_ctrl.sv @@
// ----------------------------------------------------------------------------
// tscd_ctrl
// Sequencer of the Taylor sine/cosine block. Holds the term count register
// and steps the datapath through conversion, the series terms and output.
// ----------------------------------------------------------------------------
`default_nettype none

module tscd_ctrl #(
    parameter int MAX_TERMS = 10
) (
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire                          cfg_we,
    input  wire [tscd_pkg::CNT_W-1:0]    cfg_wdata,
    input  wire                          in_valid,
    output logic                         in_ready,
    output tscd_pkg::dp_cmd_t            cmd,
    input  tscd_pkg::dp_status_t         status
);

    localparam int KW = $clog2(2 * MAX_TERMS);

    typedef enum logic [6:0] {
        S_IDLE       = 7'b0000001,
        S_CONV_RECIP = 7'b0000010,
        S_CONV_FIX   = 7'b0000100,
        S_TERM_MUL   = 7'b0001000,
        S_TERM_RECIP = 7'b0010000,
        S_TERM_FIX   = 7'b0100000,
        S_DONE       = 7'b1000000
    } state_t;

    state_t                      state_reg, state_next;
    logic [KW-1:0]               k_reg, k_next;
    logic [tscd_pkg::CNT_W-1:0]  term_count_reg;
    logic [tscd_pkg::CNT_W-1:0]  n_terms;
    logic [tscd_pkg::CNT_W:0]    last_full;
    logic [KW-1:0]               last_k;
    logic                        series_on;

    // Effective term count and the index of the last series term.
    always_comb
    begin
        n_terms   = (term_count_reg > tscd_pkg::CNT_W'(MAX_TERMS)) ?
                    tscd_pkg::CNT_W'(MAX_TERMS) : term_count_reg;
        last_full = {n_terms, 1'b0} - {{tscd_pkg::CNT_W{1'b0}}, 1'b1};
        last_k    = last_full[KW-1:0];
        series_on = (n_terms != '0);
    end

    // Term count register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            term_count_reg <= tscd_pkg::CNT_W'(5);
        end
        else if (cfg_we)
        begin
            term_count_reg <= cfg_wdata;
        end
    end

    assign in_ready = (state_reg == S_IDLE);

    // Next state, index and datapath command.
    always_comb
    begin
        state_next    = state_reg;
        k_next        = k_reg;
        cmd.op        = tscd_pkg::OP_IDLE;
        cmd.k         = tscd_pkg::K_W'(k_reg);
        cmd.series_on = series_on;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.op     = tscd_pkg::OP_LOAD;
                    state_next = S_CONV_RECIP;
                end
            end
            S_CONV_RECIP:
            begin
                cmd.op     = tscd_pkg::OP_CONV_RECIP;
                state_next = S_CONV_FIX;
            end
            S_CONV_FIX:
            begin
                cmd.op = tscd_pkg::OP_CONV_FIX;
                k_next = KW'(1);
                state_next = series_on ? S_TERM_MUL : S_DONE;
            end
            S_TERM_MUL:
            begin
                cmd.op     = tscd_pkg::OP_TERM_MUL;
                state_next = S_TERM_RECIP;
            end
            S_TERM_RECIP:
            begin
                cmd.op     = tscd_pkg::OP_TERM_RECIP;
                state_next = S_TERM_FIX;
            end
            S_TERM_FIX:
            begin
                cmd.op = tscd_pkg::OP_TERM_FIX;
                if (k_reg == last_k)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    k_next     = k_reg + KW'(1);
                    state_next = S_TERM_MUL;
                end
            end
            S_DONE:
            begin
                if (status.out_free)
                begin
                    cmd.op     = tscd_pkg::OP_PUBLISH;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and index registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            k_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            k_reg     <= k_next;
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/tscd_datapath.sv @@
// ----------------------------------------------------------------------------
// tscd_datapath
// Arithmetic of the Taylor sine/cosine block: one shared multiplier, the
// reciprocal correction steps, the two series sums and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module tscd_datapath (
    input  wire                             clk,
    input  wire                             rst_n,
    input  tscd_pkg::dp_cmd_t               cmd,
    output tscd_pkg::dp_status_t            status,
    input  wire [tscd_pkg::DEG_W-1:0]       angle_degrees,
    output logic                            m_tvalid,
    input  wire                             m_tready,
    output logic [tscd_pkg::M_DATA_W-1:0]   m_tdata
);

    // Working registers.
    logic                                  deg_neg_reg;
    logic [tscd_pkg::X_W-1:0]              x_reg;
    logic [tscd_pkg::PROD_W-1:0]           prod_reg;
    logic [tscd_pkg::A_W-1:0]              a_reg;
    logic [tscd_pkg::RAD_W-1:0]            rad_mag_reg;
    logic [tscd_pkg::TERM_W-1:0]           term_reg;
    logic signed [tscd_pkg::ACC_W-1:0]     sin_acc_reg;
    logic signed [tscd_pkg::ACC_W-1:0]     cos_acc_reg;

    // Output register.
    logic                                  out_valid_reg, out_valid_next;
    logic [tscd_pkg::RAD_W-1:0]            rad_out_reg;
    logic [tscd_pkg::SUM_W-1:0]            sin_out_reg;
    logic [tscd_pkg::SUM_W-1:0]            cos_out_reg;

    // Combinational values.
    logic [tscd_pkg::DEG_W-1:0]            deg_mag;
    logic [tscd_pkg::X_W-1:0]              deg_m;
    logic [tscd_pkg::X_W-1:0]              x_next;
    logic [tscd_pkg::MUL_A_W-1:0]          mul_a;
    logic [tscd_pkg::MUL_B_W-1:0]          mul_b;
    logic [tscd_pkg::PROD_W-1:0]           mul_p;
    logic [45:0]                           rnd_sum;
    logic [tscd_pkg::A_W-1:0]              a_next;
    logic [tscd_pkg::RAD_W-1:0]            deg_q_est;
    logic [30:0]                           deg_qk;
    logic [tscd_pkg::X_W-1:0]              deg_rem;
    logic [tscd_pkg::RAD_W-1:0]            deg_q;
    logic [tscd_pkg::RAD_W-1:0]            rad_lim;
    logic [tscd_pkg::RAD_W-1:0]            rad_mag_next;
    logic [tscd_pkg::A_W-1:0]              t_q_est;
    logic [32:0]                           t_qk;
    logic [tscd_pkg::A_W-1:0]              t_rem;
    logic [tscd_pkg::A_W-1:0]              t_q;
    logic [tscd_pkg::TERM_W-1:0]           term_next;
    logic signed [tscd_pkg::ACC_W-1:0]     t_ext;
    logic signed [tscd_pkg::ACC_W-1:0]     contrib;
    logic                                  t_minus;

    // Saturates a partial sum to the 24-bit output range.
    function automatic logic [tscd_pkg::SUM_W-1:0] sat_sum(
        input logic signed [tscd_pkg::ACC_W-1:0] v);
        logic [tscd_pkg::SUM_W-1:0] r;
        if (v > $signed(tscd_pkg::ACC_W'(24'h7FFFFF)))
        begin
            r = 24'h7FFFFF;
        end
        else if (v < -$signed(tscd_pkg::ACC_W'(24'h800000)))
        begin
            r = 24'h800000;
        end
        else
        begin
            r = v[tscd_pkg::SUM_W-1:0];
        end
        return r;
    endfunction

    // Degree magnitude scaled by 5024 with the rounding half of 1125 added.
    always_comb
    begin
        deg_mag = angle_degrees[tscd_pkg::DEG_W-1] ? (~angle_degrees + 18'd1) : angle_degrees;
        deg_m   = tscd_pkg::X_W'(deg_mag);
        x_next  = (deg_m << 12) + (deg_m << 9) + (deg_m << 8) + (deg_m << 7) + (deg_m << 5)
                  + tscd_pkg::X_W'(tscd_pkg::DEG_HALF);
    end

    // Rounded term product, ready for the divide by k.
    always_comb
    begin
        rnd_sum = {1'b0, prod_reg[44:0]} + ({41'd0, cmd.k} << 15);
        a_next  = rnd_sum[43:16];
    end

    // Shared multiplier with its operand selection.
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (cmd.op)
            tscd_pkg::OP_CONV_RECIP:
            begin
                mul_a = x_reg;
                mul_b = tscd_pkg::MUL_B_W'(tscd_pkg::DEG_RECIP);
            end
            tscd_pkg::OP_TERM_MUL:
            begin
                mul_a = tscd_pkg::MUL_A_W'(term_reg);
                mul_b = tscd_pkg::MUL_B_W'(rad_mag_reg);
            end
            tscd_pkg::OP_TERM_RECIP:
            begin
                mul_a = tscd_pkg::MUL_A_W'(a_next);
                mul_b = tscd_pkg::recip_k(cmd.k);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        mul_p = tscd_pkg::PROD_W'(mul_a) * tscd_pkg::PROD_W'(mul_b);
    end

    // Quotient correction for the radian conversion, then saturation.
    always_comb
    begin
        deg_q_est    = prod_reg[tscd_pkg::DEG_SHIFT +: tscd_pkg::RAD_W];
        deg_qk       = 31'(deg_q_est) * 31'(tscd_pkg::DEG_DEN);
        deg_rem      = x_reg - deg_qk[tscd_pkg::X_W-1:0];
        deg_q        = deg_q_est
                       + tscd_pkg::RAD_W'(deg_rem >= tscd_pkg::X_W'(tscd_pkg::DEG_DEN));
        rad_lim      = deg_neg_reg ? tscd_pkg::RAD_NEG_LIM : tscd_pkg::RAD_POS_LIM;
        rad_mag_next = (deg_q > rad_lim) ? rad_lim : deg_q;
    end

    // Quotient correction for the divide by k, and the signed contribution.
    always_comb
    begin
        t_q_est   = prod_reg[tscd_pkg::K_SHIFT +: tscd_pkg::A_W];
        t_qk      = 33'(t_q_est) * 33'(cmd.k);
        t_rem     = a_reg - t_qk[tscd_pkg::A_W-1:0];
        t_q       = t_q_est + tscd_pkg::A_W'(t_rem >= tscd_pkg::A_W'(cmd.k));
        term_next = t_q[tscd_pkg::TERM_W-1:0];
        t_ext     = $signed(tscd_pkg::ACC_W'(term_next));
        // A negative angle flips the sign of every odd power.
        t_minus   = cmd.k[1] ^ (deg_neg_reg & cmd.k[0]);
        contrib   = t_minus ? -t_ext : t_ext;
    end

    // Working registers, updated by the current operation.
    always_ff @(posedge clk)
    begin
        case (cmd.op)
            tscd_pkg::OP_LOAD:
            begin
                deg_neg_reg <= angle_degrees[tscd_pkg::DEG_W-1];
                x_reg       <= x_next;
            end
            tscd_pkg::OP_CONV_RECIP:
            begin
                prod_reg <= mul_p;
            end
            tscd_pkg::OP_CONV_FIX:
            begin
                rad_mag_reg <= rad_mag_next;
                term_reg    <= tscd_pkg::ONE_Q16;
                sin_acc_reg <= '0;
                cos_acc_reg <= cmd.series_on ?
                               $signed(tscd_pkg::ACC_W'(tscd_pkg::ONE_Q16)) : '0;
            end
            tscd_pkg::OP_TERM_MUL:
            begin
                prod_reg <= mul_p;
            end
            tscd_pkg::OP_TERM_RECIP:
            begin
                prod_reg <= mul_p;
                a_reg    <= a_next;
            end
            tscd_pkg::OP_TERM_FIX:
            begin
                term_reg <= term_next;
                if (cmd.k[0])
                begin
                    sin_acc_reg <= sin_acc_reg + contrib;
                end
                else
                begin
                    cos_acc_reg <= cos_acc_reg + contrib;
                end
            end
            default:
            begin
            end
        endcase
    end

    // Output word payload.
    always_ff @(posedge clk)
    begin
        if (cmd.op == tscd_pkg::OP_PUBLISH)
        begin
            rad_out_reg <= deg_neg_reg ? (~rad_mag_reg + 20'd1) : rad_mag_reg;
            sin_out_reg <= sat_sum(sin_acc_reg);
            cos_out_reg <= sat_sum(cos_acc_reg);
        end
    end

    // Output word valid flag.
    always_comb
    begin
        if (cmd.op == tscd_pkg::OP_PUBLISH)
        begin
            out_valid_next = 1'b1;
        end
        else
        begin
            out_valid_next = out_valid_reg & ~m_tready;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    assign status.out_free = ~out_valid_reg | m_tready;
    assign m_tvalid        = out_valid_reg;
    assign m_tdata         = {4'd0, cos_out_reg, sin_out_reg, rad_out_reg};

endmodule

`default_nettype wire

@@ rtl/core/taylor_sine_cosine_from_degrees.sv @@
// ----------------------------------------------------------------------------
// taylor_sine_cosine_from_degrees
// Converts an angle in degrees (Q9.8) to radians (Q3.16, pi taken as 3.14)
// and sums term_count Taylor terms of sine and cosine (Q7.16, saturated),
// with no range reduction. After a word is accepted the input stays closed
// until its result is published. The term count is limited to MAX_TERMS,
// its reset value is five, and with a count of zero no term is built. All
// products go through the single shared multiplier: the angle conversion
// takes two steps (multiply by the reciprocal of 1125, quotient correction),
// and each series term takes three (product with the angle, multiply by the
// reciprocal of k, quotient correction), the first two on the multiplier.
// The last step of a word waits while the output register still holds an
// unread result. A finished result waits in that register, so the next word
// is taken while the previous result has not yet been read.
// ----------------------------------------------------------------------------
`default_nettype none

module taylor_sine_cosine_from_degrees #(
    parameter int MAX_TERMS = 10
) (
    input  wire                               clk,
    input  wire                               rst_n,
    input  wire                               cfg_we,
    input  wire [tscd_pkg::CNT_W-1:0]         cfg_wdata,     // term_count
    input  wire                               s_tvalid,
    output logic                              s_tready,
    input  wire [tscd_pkg::S_DATA_W-1:0]      s_tdata,       // [17:0] angle_degrees
    output logic                              m_tvalid,
    input  wire                               m_tready,
    output logic [tscd_pkg::M_DATA_W-1:0]     m_tdata        // [19:0] angle_radians,
                                                             // [43:20] sine_value,
                                                             // [67:44] cosine_value
);

    tscd_pkg::dp_cmd_t    cmd;
    tscd_pkg::dp_status_t status;

    // Sequencer and term count register.
    tscd_ctrl #(
        .MAX_TERMS (MAX_TERMS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .cmd       (cmd),
        .status    (status)
    );

    // Arithmetic and output register.
    tscd_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .angle_degrees (s_tdata[tscd_pkg::DEG_W-1:0]),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata)
    );

    // One word at a time: after an accepted word the input side closes.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input accepted while a word is still in work");

    // A new result only appears while a word is in work.
    a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(!s_tready))
        else $error("result appeared with no word in work");

    // The controller never overwrites a result that has not been taken.
    a_publish_free: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == tscd_pkg::OP_PUBLISH) |-> status.out_free)
        else $error("result published over a pending output word");

endmodule

`default_nettype wire
